### design/debounced_motion_event_logger_macros.svh
// Assertion macros used by the checker of the motion event logger.
`ifndef DEBOUNCED_MOTION_EVENT_LOGGER_MACROS_SVH
`define DEBOUNCED_MOTION_EVENT_LOGGER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DMEL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DMEL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/dmel_pkg.sv
// Types and constants shared by the motion event logger modules.
package dmel_pkg;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_START  = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_POLL_INTERVAL = 1'b0,
    REG_DEBOUNCE      = 1'b1
  } cfg_reg_t;

  localparam logic [15:0] POLL_INTERVAL_RESET = 16'd50;
  localparam logic [15:0] DEBOUNCE_RESET      = 16'd60;
  localparam logic [31:0] EPOCH_VALID_MIN     = 32'd1600000000;

  // Input request payload, last declared field in the lowest bits.
  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] since_seq;
    logic [31:0] wall_epoch;
    logic [31:0] now_ms;
    logic        raw_level;
  } in_data_t;

  // Result payload, last declared field in the lowest bits.
  typedef struct packed {
    logic [2:0]  pad;
    logic [10:0] entries_held;
    logic [31:0] latest_seq_out;
    logic [31:0] detections;
    logic        entry_motion;
    logic [31:0] entry_uptime;
    logic [31:0] entry_epoch;
    logic [31:0] entry_seq;
    logic        active;
  } out_data_t;

  // Result flags carried beside the payload.
  typedef struct packed {
    logic found;
    logic event_logged;
  } out_flags_t;

  // One word of the log memory.
  typedef struct packed {
    logic [31:0] wall_time;
    logic [31:0] up_time;
    logic        level;
  } log_entry_t;

endpackage

### design/dmel_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module dmel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/debounced_motion_event_logger.sv
// Top level of the debounced motion event logger.
//
// Requests arrive on the in_ stream: in_tuser carries the operation (sample,
// read, clear or start) and in_tdata the sensor level, uptime, wall time and
// the read threshold. Every request gives exactly one result on the out_
// stream: the debounced state, the logged or read entry, the detection count,
// the last sequence and the log fill level, with the logged and found flags
// on out_tuser.
// Sample, clear and start requests complete in one cycle: the result is valid
// the cycle after acceptance and a new request may follow at once. A read
// request passes through ST_READ, as the log memory has a single synchronous read
// port (address in the accept cycle, data in the cycle after).
// The result sits in an output register; a new request is taken while the
// current result is being taken, and a stalled receiver holds off in_tready.
// Reset clears the debounce state, the counters and the log pointers and
// loads the register defaults (poll 50 ms, debounce 60 ms); the log memory
// needs no clearing pass, as only entries held in the log are ever read.
// Configuration writes on cfg_ are always taken and apply from the next request.
module debounced_motion_event_logger
  import dmel_pkg::*;
#(
  parameter int LOG_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  // Request stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // raw_level, now_ms, wall_epoch, since_seq, zero pad
  input  logic [1:0]   in_tuser,   // op
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [175:0] out_tdata,  // active, entry_seq, entry_epoch, entry_uptime,
                                   // entry_motion, detections, latest_seq_out,
                                   // entries_held, zero pad
  output logic [1:0]   out_tuser,  // event_logged, found
  // Configuration write channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int AW = $clog2(LOG_DEPTH);
  localparam int CW = $clog2(LOG_DEPTH + 1);
  localparam int SW = AW + 1;
  localparam int EW = $bits(log_entry_t);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t         state_r, state_nxt;
  logic [15:0]    poll_r, debounce_r;
  logic           deb_r, deb_nxt;
  logic           last_raw_r, last_raw_nxt;
  logic [31:0]    change_time_r, change_time_nxt;
  logic [31:0]    sample_time_r, sample_time_nxt;
  logic [AW-1:0]  write_slot_r, write_slot_nxt;
  logic [CW-1:0]  total_r, total_nxt;
  logic [31:0]    last_seq_r, last_seq_nxt;
  logic [31:0]    detect_r, detect_nxt;
  logic           found_r, found_nxt;
  logic [31:0]    rd_seq_r, rd_seq_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_data_t      out_data_r, out_data_nxt;
  out_flags_t     out_flags_r, out_flags_nxt;

  in_data_t       req;
  op_t            op;
  logic           in_acc;
  logic           commit;
  logic [31:0]    wall_kept;
  logic           wr_en;
  log_entry_t     wr_entry;
  log_entry_t     rd_entry;
  logic [EW-1:0]  rd_word;
  logic           rd_en;
  logic [AW-1:0]  rd_slot;
  logic [31:0]    base_seq;
  logic [31:0]    since_diff;
  logic [32:0]    since_step;
  logic [CW-1:0]  rd_index;
  logic [SW-1:0]  oldest_sum, oldest, slot_sum;

  assign req       = in_data_t'(in_tdata);
  assign op        = op_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Locate the oldest held entry whose sequence exceeds since_seq.
  always_comb begin
    base_seq   = last_seq_r - 32'(total_r) + 32'd1;
    since_diff = req.since_seq - base_seq;
    since_step = {1'b0, since_diff} + 33'd1;
    found_nxt  = 1'b0;
    rd_index   = '0;
    rd_seq_nxt = '0;
    if (total_r != '0) begin
      if (base_seq > req.since_seq) begin
        found_nxt  = 1'b1;
        rd_seq_nxt = base_seq;
      end else if (req.since_seq != '1 && since_step < 33'(total_r)) begin
        found_nxt  = 1'b1;
        rd_index   = CW'(since_step);
        rd_seq_nxt = req.since_seq + 32'd1;
      end
    end
    oldest_sum = SW'(write_slot_r) + SW'(LOG_DEPTH) - SW'(total_r);
    oldest     = (oldest_sum >= SW'(LOG_DEPTH)) ? oldest_sum - SW'(LOG_DEPTH) : oldest_sum;
    slot_sum   = oldest + SW'(rd_index);
    rd_slot    = AW'((slot_sum >= SW'(LOG_DEPTH)) ? slot_sum - SW'(LOG_DEPTH) : slot_sum);
  end

  assign rd_en = in_acc && (op == OP_READ);

  // Request processing: state update and result formation.
  always_comb begin
    state_nxt       = state_r;
    deb_nxt         = deb_r;
    last_raw_nxt    = last_raw_r;
    change_time_nxt = change_time_r;
    sample_time_nxt = sample_time_r;
    write_slot_nxt  = write_slot_r;
    total_nxt       = total_r;
    last_seq_nxt    = last_seq_r;
    detect_nxt      = detect_r;
    commit          = 1'b0;
    wall_kept       = (req.wall_epoch > EPOCH_VALID_MIN) ? req.wall_epoch : 32'd0;
    out_data_nxt    = out_data_r;
    out_flags_nxt   = out_flags_r;
    out_valid_nxt   = out_tready ? 1'b0 : out_valid_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (op)
            OP_SAMPLE: begin
              if ((req.now_ms - sample_time_r) >= 32'(poll_r)) begin
                sample_time_nxt = req.now_ms;
                if (req.raw_level != last_raw_r) begin
                  last_raw_nxt    = req.raw_level;
                  change_time_nxt = req.now_ms;
                end else if (req.raw_level != deb_r &&
                             (req.now_ms - change_time_r) >= 32'(debounce_r)) begin
                  commit         = 1'b1;
                  deb_nxt        = req.raw_level;
                  last_seq_nxt   = last_seq_r + 32'd1;
                  write_slot_nxt = (write_slot_r == AW'(LOG_DEPTH - 1)) ? '0
                                                                     : write_slot_r + AW'(1);
                  if (total_r != CW'(LOG_DEPTH)) begin
                    total_nxt = total_r + CW'(1);
                  end
                  if (req.raw_level) begin
                    detect_nxt = detect_r + 32'd1;
                  end
                end
              end
            end
            OP_READ: begin
              state_nxt = ST_READ;
            end
            OP_CLEAR: begin
              write_slot_nxt = '0;
              total_nxt      = '0;
              last_seq_nxt   = '0;
              detect_nxt     = '0;
            end
            OP_START: begin
              deb_nxt         = req.raw_level;
              last_raw_nxt    = req.raw_level;
              change_time_nxt = req.now_ms;
              sample_time_nxt = req.now_ms;
            end
          endcase

          // Non-read requests finish in this cycle.
          if (op != OP_READ) begin
            out_valid_nxt              = 1'b1;
            out_flags_nxt.event_logged = commit;
            out_flags_nxt.found        = 1'b0;
            out_data_nxt.pad           = '0;
            out_data_nxt.active        = deb_nxt;
            out_data_nxt.entry_seq     = commit ? last_seq_nxt : 32'd0;
            out_data_nxt.entry_epoch   = commit ? wall_kept : 32'd0;
            out_data_nxt.entry_uptime  = commit ? req.now_ms : 32'd0;
            out_data_nxt.entry_motion  = commit & req.raw_level;
            out_data_nxt.detections    = detect_nxt;
            out_data_nxt.latest_seq_out = last_seq_nxt;
            out_data_nxt.entries_held  = 11'(total_nxt);
          end
        end
      end
      ST_READ: begin
        // Memory data has arrived; the output register is free by now.
        state_nxt                  = ST_IDLE;
        out_valid_nxt              = 1'b1;
        out_flags_nxt.event_logged = 1'b0;
        out_flags_nxt.found        = found_r;
        out_data_nxt.pad           = '0;
        out_data_nxt.active        = deb_r;
        out_data_nxt.entry_seq     = found_r ? rd_seq_r : 32'd0;
        out_data_nxt.entry_epoch   = found_r ? rd_entry.wall_time : 32'd0;
        out_data_nxt.entry_uptime  = found_r ? rd_entry.up_time : 32'd0;
        out_data_nxt.entry_motion  = found_r & rd_entry.level;
        out_data_nxt.detections    = detect_r;
        out_data_nxt.latest_seq_out = last_seq_r;
        out_data_nxt.entries_held  = 11'(total_r);
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Log write on each committed change.
  assign wr_en              = commit;
  assign wr_entry.wall_time = wall_kept;
  assign wr_entry.up_time   = req.now_ms;
  assign wr_entry.level     = req.raw_level;
  assign rd_entry           = log_entry_t'(rd_word);

  dmel_ram #(
    .WIDTH (EW),
    .DEPTH (LOG_DEPTH)
  ) u_log_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (write_slot_r),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_slot),
    .rd_data (rd_word)
  );

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      poll_r        <= POLL_INTERVAL_RESET;
      debounce_r    <= DEBOUNCE_RESET;
      deb_r         <= 1'b0;
      last_raw_r    <= 1'b0;
      change_time_r <= '0;
      sample_time_r <= '0;
      write_slot_r  <= '0;
      total_r       <= '0;
      last_seq_r    <= '0;
      detect_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      deb_r         <= deb_nxt;
      last_raw_r    <= last_raw_nxt;
      change_time_r <= change_time_nxt;
      sample_time_r <= sample_time_nxt;
      write_slot_r  <= write_slot_nxt;
      total_r       <= total_nxt;
      last_seq_r    <= last_seq_nxt;
      detect_r      <= detect_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_POLL_INTERVAL: poll_r     <= cfg_data;
          REG_DEBOUNCE:      debounce_r <= cfg_data;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_flags_r <= out_flags_nxt;
    if (rd_en) begin
      found_r  <= found_nxt;
      rd_seq_r <= rd_seq_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flags_r;

endmodule

### design/dmel_checker.sv
// Port-level checker for the motion event logger, bound to the top level.
`include "debounced_motion_event_logger_macros.svh"

module dmel_checker
  import dmel_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [175:0] out_tdata,
  input logic [1:0]   out_tuser
);

  out_data_t  res;
  out_flags_t flg;

  assign res = out_data_t'(out_tdata);
  assign flg = out_flags_t'(out_tuser);

  // A stalled result holds until it is taken.
  `DMEL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // A sample, clear or start request has its result ready in the next cycle.
  `DMEL_ASSERT_NEXT(a_quick_result, in_tvalid && in_tready && op_t'(in_tuser) != OP_READ, out_tvalid, "no result after a one-cycle request")

  // A result cannot be both a logged change and a read hit.
  `DMEL_ASSERT_NOW(a_flags_excl, out_tvalid, !(flg.event_logged && flg.found), "logged and found both set")

  // Without a logged or found entry the entry fields are zero.
  `DMEL_ASSERT_NOW(a_empty_entry, out_tvalid && !flg.event_logged && !flg.found, res.entry_seq == 32'd0 && res.entry_epoch == 32'd0 && res.entry_uptime == 32'd0 && !res.entry_motion, "entry fields set without an entry")

  // A logged change carries the newest sequence, its own level and a valid or zero wall time.
  `DMEL_ASSERT_NOW(a_logged_entry, out_tvalid && flg.event_logged, res.entry_seq == res.latest_seq_out && res.entry_motion == res.active && (res.entry_epoch == 32'd0 || res.entry_epoch > EPOCH_VALID_MIN), "logged entry inconsistent")

endmodule

bind debounced_motion_event_logger dmel_checker u_dmel_checker (.*);
